// ----- rtl/core/two_state_turing_machine_runner_top_assert.svh -----
// assertion macros for the turing machine runner
// each expects clk and rst_n in the scope of use
`ifndef TWO_STATE_TURING_MACHINE_RUNNER_TOP_ASSERT_SVH
`define TWO_STATE_TURING_MACHINE_RUNNER_TOP_ASSERT_SVH

// condition that must hold at every edge out of reset
`define TSTM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TSTM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tstm_pkg.sv -----
`timescale 1ns / 1ps

package tstm_pkg;

    typedef struct packed {
        logic [4:0] action_a_zero;
        logic [4:0] action_a_one;
        logic [4:0] action_b_zero;
        logic [4:0] action_b_one;
    } prog_item_t;

    typedef struct packed {
        logic [31:0] run_number;
        logic [5:0]  last_a_step;
        logic [5:0]  last_b_step;
        logic        reported;
        logic        status;
    } res_item_t;

    // controller to datapath
    typedef struct packed {
        logic init;
        logic step;
        logic exec;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic limit;
        logic halt;
        logic undef;
    } dp_status_t;

    localparam int BOUND_W = 6;
    localparam int MARK_OUT_W = 6;

    // next-state codes in an action word
    localparam logic [2:0] NEXT_A    = 3'd0;
    localparam logic [2:0] NEXT_B    = 3'd1;
    localparam logic [2:0] NEXT_HALT = 3'd7;

    localparam logic MS_A = 1'b0;
    localparam logic MS_B = 1'b1;

    // register indexes
    localparam logic [0:0] REG_LOWER = 1'b0;
    localparam logic [0:0] REG_UPPER = 1'b1;

    localparam logic [BOUND_W-1:0] LOWER_RESET = 6'd2;
    localparam logic [BOUND_W-1:0] UPPER_RESET = 6'd20;

endpackage

// ----- rtl/core/two_state_turing_machine_runner_top.sv -----
// the result becomes valid once the run halts, enters an undefined state or hits the step limit
// a new program is taken only after the last result is loaded; a held result delays the next
// each step passes through a read state and an execute state on the tape ram
// the tape needs no clearing pass: cells outside the range written in this run read as 0
// reset: bounds return to 2 and 20, run counter to 0, controller to idle, no result held
`timescale 1ns / 1ps

`include "two_state_turing_machine_runner_top_assert.svh"

module two_state_turing_machine_runner_top #(
    parameter int MAX_STEPS  = 40,
    parameter int TAPE_CELLS = 90
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 prog_valid,
    output logic                 prog_stall,
    input  tstm_pkg::prog_item_t prog,
    output logic                 res_valid,
    input  logic                 res_stall,
    output tstm_pkg::res_item_t  res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [tstm_pkg::BOUND_W-1:0] lower_reg;
    logic [tstm_pkg::BOUND_W-1:0] upper_reg;
    logic                         cfg_write;
    logic [0:0]                   reg_index;

    tstm_pkg::dp_cmd_t    cmd;
    tstm_pkg::dp_status_t dp_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= tstm_pkg::LOWER_RESET;
            upper_reg <= tstm_pkg::UPPER_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                tstm_pkg::REG_LOWER: lower_reg <= pwdata[tstm_pkg::BOUND_W-1:0];
                tstm_pkg::REG_UPPER: upper_reg <= pwdata[tstm_pkg::BOUND_W-1:0];
                default:             lower_reg <= lower_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            tstm_pkg::REG_LOWER: prdata = 32'(lower_reg);
            tstm_pkg::REG_UPPER: prdata = 32'(upper_reg);
            default:             prdata = '0;
        endcase
    end

    tstm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .prog_valid (prog_valid),
        .prog_stall (prog_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .cmd        (cmd),
        .status     (dp_status)
    );

    tstm_datapath #(
        .MAX_STEPS  (MAX_STEPS),
        .TAPE_CELLS (TAPE_CELLS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (dp_status),
        .prog        (prog),
        .bound_lo    (lower_reg),
        .bound_hi    (upper_reg),
        .res         (res)
    );

    `TSTM_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
    `TSTM_ASSERT_NEXT(a_busy_after_accept, prog_valid && !prog_stall, prog_stall,
                      "not busy after taking a program")
    `TSTM_ASSERT_NEXT(a_load_gives_result, cmd.load_out, res_valid,
                      "result not shown after load")
    `TSTM_ASSERT_NEXT(a_limit_skips_exec, cmd.step && dp_status.limit, !cmd.exec,
                      "step executed past the limit")

endmodule

// ----- rtl/core/tstm_ram.sv -----
`timescale 1ns / 1ps

module tstm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 90
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/tstm_datapath.sv -----
`timescale 1ns / 1ps

module tstm_datapath #(
    parameter int MAX_STEPS  = 40,
    parameter int TAPE_CELLS = 90
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tstm_pkg::dp_cmd_t                cmd,
    output tstm_pkg::dp_status_t             status,
    input  tstm_pkg::prog_item_t             prog,
    input  logic [tstm_pkg::BOUND_W-1:0]     bound_lo,
    input  logic [tstm_pkg::BOUND_W-1:0]     bound_hi,
    output tstm_pkg::res_item_t              res
);

    localparam int HEAD_W = $clog2(TAPE_CELLS);
    localparam int STEP_W = $clog2(MAX_STEPS + 2);
    localparam int DISP_W = $clog2(MAX_STEPS + 1) + 1;
    localparam int SPAN_W = (DISP_W + 1 > $clog2(TAPE_CELLS) + 1) ?
                            DISP_W + 1 : $clog2(TAPE_CELLS) + 1;
    localparam int CMP_W  = (STEP_W > tstm_pkg::BOUND_W) ? STEP_W : tstm_pkg::BOUND_W;

    localparam logic [HEAD_W-1:0] HEAD_START = HEAD_W'(TAPE_CELLS / 2);
    localparam logic [HEAD_W-1:0] HEAD_LAST  = HEAD_W'(TAPE_CELLS - 1);

    tstm_pkg::prog_item_t prog_reg;
    tstm_pkg::res_item_t  res_reg;

    logic [31:0]              run_cnt_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        a_mark_reg;
    logic [STEP_W-1:0]        b_mark_reg;
    logic                     mstate_reg;
    logic [HEAD_W-1:0]        head_reg;
    logic signed [DISP_W-1:0] disp_reg;
    logic signed [DISP_W-1:0] dmin_reg;
    logic signed [DISP_W-1:0] dmax_reg;
    logic                     wr_any_reg;
    logic                     undef_reg;

    logic [STEP_W-1:0]        step_next;
    logic                     limit;
    logic signed [DISP_W:0]   spread;
    logic                     tape_full;
    logic                     disp_seen;
    logic                     cell_bit;
    logic                     tape_rdata;
    logic [4:0]               word;
    logic [2:0]               next_st;
    logic                     halt;
    logic                     undef;
    logic [HEAD_W-1:0]        head_next;
    logic signed [DISP_W-1:0] disp_next;
    logic                     a_in;
    logic                     b_in;
    logic                     reported;

    assign step_next = step_reg + STEP_W'(1);
    assign limit     = step_next > STEP_W'(MAX_STEPS);

    // cells written this run form one contiguous run of displacements
    assign spread    = (DISP_W + 1)'(dmax_reg) - (DISP_W + 1)'(dmin_reg);
    assign tape_full = SPAN_W'(spread) >= $signed(SPAN_W'(TAPE_CELLS - 1));
    assign disp_seen = (disp_reg >= dmin_reg) && (disp_reg <= dmax_reg);
    assign cell_bit  = (wr_any_reg && (tape_full || disp_seen)) ? tape_rdata : 1'b0;

    always_comb
    begin
        case ({mstate_reg, cell_bit})
            2'b00:   word = prog_reg.action_a_zero;
            2'b01:   word = prog_reg.action_a_one;
            2'b10:   word = prog_reg.action_b_zero;
            2'b11:   word = prog_reg.action_b_one;
            default: word = prog_reg.action_a_zero;
        endcase
    end

    assign next_st = word[4:2];
    assign halt    = next_st == tstm_pkg::NEXT_HALT;
    assign undef   = !(next_st inside {tstm_pkg::NEXT_A, tstm_pkg::NEXT_B,
                                       tstm_pkg::NEXT_HALT});

    always_comb
    begin
        if (word[1])
        begin
            head_next = (head_reg == HEAD_LAST) ? '0 : head_reg + HEAD_W'(1);
            disp_next = disp_reg + DISP_W'(1);
        end
        else
        begin
            head_next = (head_reg == '0) ? HEAD_LAST : head_reg - HEAD_W'(1);
            disp_next = disp_reg - DISP_W'(1);
        end
    end

    assign status.limit = limit;
    assign status.halt  = halt;
    assign status.undef = undef;

    tstm_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .clk   (clk),
        .we    (cmd.exec),
        .waddr (head_reg),
        .wdata (word[0]),
        .raddr (head_reg),
        .rdata (tape_rdata)
    );

    assign a_in = (CMP_W'(bound_lo) <= CMP_W'(a_mark_reg)) &&
                  (CMP_W'(a_mark_reg) < CMP_W'(bound_hi));
    assign b_in = (CMP_W'(bound_lo) <= CMP_W'(b_mark_reg)) &&
                  (CMP_W'(b_mark_reg) < CMP_W'(bound_hi));
    assign reported = !undef_reg && (a_mark_reg != '0) && (b_mark_reg != '0) &&
                      (a_in || b_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
            step_reg    <= '0;
            a_mark_reg  <= '0;
            b_mark_reg  <= '0;
            mstate_reg  <= tstm_pkg::MS_A;
            head_reg    <= HEAD_START;
            disp_reg    <= '0;
            dmin_reg    <= '0;
            dmax_reg    <= '0;
            wr_any_reg  <= 1'b0;
            undef_reg   <= 1'b0;
        end
        else if (cmd.init)
        begin
            run_cnt_reg <= run_cnt_reg + 32'd1;
            step_reg    <= '0;
            a_mark_reg  <= '0;
            b_mark_reg  <= '0;
            mstate_reg  <= tstm_pkg::MS_A;
            head_reg    <= HEAD_START;
            disp_reg    <= '0;
            dmin_reg    <= '0;
            dmax_reg    <= '0;
            wr_any_reg  <= 1'b0;
            undef_reg   <= 1'b0;
        end
        else if (cmd.step)
        begin
            step_reg <= step_next;
            if (!limit)
            begin
                if (mstate_reg == tstm_pkg::MS_A)
                begin
                    a_mark_reg <= step_next;
                end
                else
                begin
                    b_mark_reg <= step_next;
                end
            end
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            disp_reg   <= disp_next;
            wr_any_reg <= 1'b1;
            if (!wr_any_reg)
            begin
                dmin_reg <= disp_reg;
                dmax_reg <= disp_reg;
            end
            else
            begin
                if (disp_reg < dmin_reg)
                begin
                    dmin_reg <= disp_reg;
                end
                if (disp_reg > dmax_reg)
                begin
                    dmax_reg <= disp_reg;
                end
            end
            if (undef)
            begin
                undef_reg <= 1'b1;
            end
            else if (!halt)
            begin
                mstate_reg <= next_st[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            prog_reg <= prog;
        end
        if (cmd.load_out)
        begin
            res_reg.run_number  <= run_cnt_reg;
            res_reg.last_a_step <= tstm_pkg::MARK_OUT_W'(CMP_W'(a_mark_reg));
            res_reg.last_b_step <= tstm_pkg::MARK_OUT_W'(CMP_W'(b_mark_reg));
            res_reg.reported    <= reported;
            res_reg.status      <= undef_reg;
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/core/tstm_ctrl.sv -----
`timescale 1ns / 1ps

module tstm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 prog_valid,
    output logic                 prog_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    output tstm_pkg::dp_cmd_t    cmd,
    input  tstm_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   res_valid_reg;
    logic   slot_free;

    // output register can take a new item when empty or being drained
    assign slot_free = !res_valid_reg || !res_stall;

    assign prog_stall   = state_reg != S_IDLE;
    assign res_valid    = res_valid_reg;

    assign cmd.init     = (state_reg == S_IDLE) && prog_valid;
    assign cmd.step     = state_reg == S_STEP;
    assign cmd.exec     = state_reg == S_EXEC;
    assign cmd.load_out = (state_reg == S_FINISH) && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_FINISH) && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (prog_valid)
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (status.limit)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (status.halt || status.undef)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/tstm_run_checker.sv -----
`timescale 1ns / 1ps

module tstm_run_checker #(
    parameter int MAX_STEPS  = 40,
    parameter int TAPE_CELLS = 90
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 prog_valid,
    input  logic                 prog_stall,
    input  tstm_pkg::prog_item_t prog,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  tstm_pkg::res_item_t  res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output int                   mismatches,
    output int                   awaiting,
    output int                   results_checked,
    output int                   reported_seen
);

    localparam logic [2:0] LOWER_ADDR = {tstm_pkg::REG_LOWER, 2'b00};
    localparam logic [2:0] UPPER_ADDR = {tstm_pkg::REG_UPPER, 2'b00};

    logic [tstm_pkg::BOUND_W-1:0] lo_bound_q;
    logic [tstm_pkg::BOUND_W-1:0] hi_bound_q;
    logic [31:0]                  programs_seen;
    tstm_pkg::res_item_t          expected_results[$];
    int                           fail_count;
    int                           checked_count;
    int                           reported_count;

    // runs one program from a blank tape and returns the result it should give
    function automatic tstm_pkg::res_item_t run_machine(tstm_pkg::prog_item_t p,
                                                        logic [31:0] run_no,
                                                        logic [tstm_pkg::BOUND_W-1:0] lo,
                                                        logic [tstm_pkg::BOUND_W-1:0] hi);
        logic [TAPE_CELLS-1:0] tape;
        int unsigned           head;
        logic                  st;
        int unsigned           steps;
        int unsigned           a_mark;
        int unsigned           b_mark;
        logic [4:0]            word;
        logic [2:0]            nxt;
        logic                  undef;
        tstm_pkg::res_item_t   r;
        tape   = '0;
        head   = TAPE_CELLS / 2;
        st     = tstm_pkg::MS_A;
        a_mark = 0;
        b_mark = 0;
        undef  = 1'b0;
        // a step is counted before it runs, so the limit ends the loop
        for (steps = 1; steps <= MAX_STEPS; steps++)
        begin
            if (st == tstm_pkg::MS_A)
                a_mark = steps;
            else
                b_mark = steps;
            case ({st, tape[head]})
                2'b00:   word = p.action_a_zero;
                2'b01:   word = p.action_a_one;
                2'b10:   word = p.action_b_zero;
                default: word = p.action_b_one;
            endcase
            tape[head] = word[0];
            if (word[1])
                head = (head + 1 >= TAPE_CELLS) ? 0 : head + 1;
            else
                head = (head == 0) ? TAPE_CELLS - 1 : head - 1;
            nxt = word[4:2];
            if (nxt == tstm_pkg::NEXT_HALT)
                break;
            if (nxt != tstm_pkg::NEXT_A && nxt != tstm_pkg::NEXT_B)
            begin
                undef = 1'b1;
                break;
            end
            st = (nxt == tstm_pkg::NEXT_B) ? tstm_pkg::MS_B : tstm_pkg::MS_A;
        end
        r.run_number  = run_no;
        r.last_a_step = a_mark[tstm_pkg::MARK_OUT_W-1:0];
        r.last_b_step = b_mark[tstm_pkg::MARK_OUT_W-1:0];
        r.status      = undef;
        r.reported    = !undef && a_mark != 0 && b_mark != 0 &&
                        ((lo <= a_mark && a_mark < hi) || (lo <= b_mark && b_mark < hi));
        return r;
    endfunction

    task automatic flag(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tstm_pkg::res_item_t want;
        if (!rst_n)
        begin
            lo_bound_q = tstm_pkg::LOWER_RESET;
            hi_bound_q = tstm_pkg::UPPER_RESET;
            programs_seen = '0;
            expected_results.delete();
            fail_count     = 0;
            checked_count  = 0;
            reported_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    LOWER_ADDR: lo_bound_q = pwdata[tstm_pkg::BOUND_W-1:0];
                    UPPER_ADDR: hi_bound_q = pwdata[tstm_pkg::BOUND_W-1:0];
                    default: ;
                endcase
            end
            // older results leave before the new item's expectation joins
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, run %0d", $time, res.run_number);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (res.reported)
                        reported_count++;
                    if (res.run_number !== want.run_number)
                        flag("run_number", want.run_number, res.run_number);
                    if (res.last_a_step !== want.last_a_step)
                        flag("last_a_step", want.last_a_step, res.last_a_step);
                    if (res.last_b_step !== want.last_b_step)
                        flag("last_b_step", want.last_b_step, res.last_b_step);
                    if (res.reported !== want.reported)
                        flag("reported", want.reported, res.reported);
                    if (res.status !== want.status)
                        flag("status", want.status, res.status);
                end
            end
            if (prog_valid && !prog_stall)
            begin
                programs_seen = programs_seen + 1;
                expected_results.push_back(run_machine(prog, programs_seen,
                                                       lo_bound_q, hi_bound_q));
            end
        end
        mismatches      <= fail_count;
        awaiting        <= expected_results.size();
        results_checked <= checked_count;
        reported_seen   <= reported_count;
    end

endmodule

// ----- tb/two_state_turing_machine_runner_top_tb.sv -----
`timescale 1ns / 1ps

module two_state_turing_machine_runner_top_tb;

    localparam int MAX_STEPS   = 40;
    localparam int TAPE_CELLS  = 90;
    localparam int CYCLE_LIMIT = 600000;
    localparam int CHUNKS      = 7;
    localparam int CHUNK_ITEMS = 150;
    localparam bit MOVE_LEFT   = 1'b0;
    localparam bit MOVE_RIGHT  = 1'b1;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 prog_valid = 1'b0;
    logic                 prog_stall;
    tstm_pkg::prog_item_t prog       = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    tstm_pkg::res_item_t  res;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [2:0]           paddr      = '0;
    logic [31:0]          pwdata     = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int mismatches;
    int awaiting;
    int results_checked;
    int reported_seen;
    int cycle_count    = 0;
    int programs_sent  = 0;
    int settings_used  = 1;
    bit idle_on        = 1'b1;
    int stall_left     = 0;

    always #6 clk = ~clk;

    two_state_turing_machine_runner_top #(
        .MAX_STEPS  (MAX_STEPS),
        .TAPE_CELLS (TAPE_CELLS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .prog_valid (prog_valid),
        .prog_stall (prog_stall),
        .prog       (prog),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tstm_run_checker #(
        .MAX_STEPS  (MAX_STEPS),
        .TAPE_CELLS (TAPE_CELLS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .prog_valid      (prog_valid),
        .prog_stall      (prog_stall),
        .prog            (prog),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .reported_seen   (reported_seen)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver back-pressure in short bursts
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left = 0;
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    function automatic logic [4:0] act(bit wr, bit right, logic [2:0] nxt);
        return {nxt, right, wr};
    endfunction

    function automatic logic [4:0] random_action();
        logic [2:0] nxt;
        int         pick;
        pick = $urandom_range(0, 15);
        if (pick < 6)
            nxt = tstm_pkg::NEXT_A;
        else if (pick < 12)
            nxt = tstm_pkg::NEXT_B;
        else if (pick < 15)
            nxt = tstm_pkg::NEXT_HALT;
        else
            nxt = 3'($urandom_range(2, 6));
        return act(1'($urandom), 1'($urandom), nxt);
    endfunction

    // leaves valid up after acceptance; the caller drives the next item in the same step
    task automatic send_prog(tstm_pkg::prog_item_t p);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            prog_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        prog_valid <= 1'b1;
        prog       <= p;
        @(posedge clk);
        while (prog_stall)
            @(posedge clk);
        programs_sent++;
    endtask

    task automatic drain();
        prog_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bounds(logic [5:0] lo, logic [5:0] hi);
        drain();
        repeat (4) @(posedge clk);
        write_reg(tstm_pkg::REG_LOWER, 32'(lo));
        write_reg(tstm_pkg::REG_UPPER, 32'(hi));
        settings_used++;
    endtask

    task automatic send_directed();
        tstm_pkg::prog_item_t p;
        logic [2:0]           nx;
        p = '0;
        send_prog(p);
        p = '1;
        send_prog(p);
        // classic two-state champion, halts from B
        p = {act(1'b1, MOVE_RIGHT, tstm_pkg::NEXT_B), act(1'b1, MOVE_LEFT, tstm_pkg::NEXT_B),
             act(1'b1, MOVE_LEFT, tstm_pkg::NEXT_A), act(1'b1, MOVE_RIGHT, tstm_pkg::NEXT_HALT)};
        send_prog(p);
        // ping-pong between A and B until the step limit
        p = {act(1'b0, MOVE_RIGHT, tstm_pkg::NEXT_B), 5'd0,
             act(1'b0, MOVE_RIGHT, tstm_pkg::NEXT_A), 5'd0};
        send_prog(p);
        // stuck in A / stuck in B
        p = {act(1'b1, MOVE_LEFT, tstm_pkg::NEXT_A), 5'd0, 5'd0, 5'd0};
        send_prog(p);
        p = {act(1'b0, MOVE_RIGHT, tstm_pkg::NEXT_B), 5'd0,
             act(1'b0, MOVE_RIGHT, tstm_pkg::NEXT_B), 5'd0};
        send_prog(p);
        // every undefined next state, entered from A
        for (nx = 3'd2; nx <= 3'd6; nx++)
        begin
            p = {act(1'b1, MOVE_RIGHT, nx), 5'd0, 5'd0, 5'd0};
            send_prog(p);
        end
        // undefined state entered from B
        p = {act(1'b1, MOVE_RIGHT, tstm_pkg::NEXT_B), 5'd0, act(1'b0, MOVE_LEFT, 3'd5), 5'd0};
        send_prog(p);
        // A reads a one and halts
        p = {act(1'b1, MOVE_RIGHT, tstm_pkg::NEXT_B), act(1'b0, MOVE_RIGHT, tstm_pkg::NEXT_HALT),
             act(1'b0, MOVE_LEFT, tstm_pkg::NEXT_A), 5'd0};
        send_prog(p);
        // B reads a one and halts
        p = {act(1'b1, MOVE_RIGHT, tstm_pkg::NEXT_B), 5'd0,
             act(1'b1, MOVE_LEFT, tstm_pkg::NEXT_B), act(1'b0, MOVE_LEFT, tstm_pkg::NEXT_HALT)};
        send_prog(p);
        p = {5'h15, 5'h0A, 5'h15, 5'h0A};
        send_prog(p);
        p = {5'h0A, 5'h15, 5'h0A, 5'h15};
        send_prog(p);
        // halt on the very first step, writing 0 moving left and writing 1 moving right
        p = {act(1'b0, MOVE_LEFT, tstm_pkg::NEXT_HALT), 5'h1F, 5'h1F, 5'h1F};
        send_prog(p);
        p = {act(1'b1, MOVE_RIGHT, tstm_pkg::NEXT_HALT), 5'd0, 5'd0, 5'd0};
        send_prog(p);
    endtask

    initial
    begin
        tstm_pkg::prog_item_t p;
        logic [5:0]           lo_table[CHUNKS];
        logic [5:0]           hi_table[CHUNKS];
        lo_table = '{6'd2, 6'd0, 6'd41, 6'd0, 6'd63, 6'd5, 6'd0};
        hi_table = '{6'd20, 6'd41, 6'd0, 6'd0, 6'd63, 6'd12, 6'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            if (chunk == CHUNKS - 1)
            begin
                lo_table[chunk] = 6'($urandom_range(0, 63));
                hi_table[chunk] = 6'($urandom_range(0, 63));
            end
            if (chunk != 0)
                set_bounds(lo_table[chunk], hi_table[chunk]);
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    idle_on = (chunk != CHUNKS - 1) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 99) == 0)
                    drain();
                if ($urandom_range(0, 7) == 0)
                    p = tstm_pkg::prog_item_t'(20'($urandom_range(0, 20'hFFFFF)));
                else
                    p = {random_action(), random_action(), random_action(), random_action()};
                send_prog(p);
            end
        end
        drain();
        repeat (90) @(posedge clk);

        $display("ran %0d programs under %0d bound settings, extremes and inverted ranges included",
                 programs_sent, settings_used);
        $display("%0d results compared, %0d flagged for report", results_checked, reported_seen);
        if (mismatches == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
